// ===== hw/rtl/affine_warp_nearest_clamp_assert.svh =====
// Assertion helpers; the using module provides clk and arst_n.
`ifndef AFFINE_WARP_NEAREST_CLAMP_ASSERT_SVH
`define AFFINE_WARP_NEAREST_CLAMP_ASSERT_SVH

// Same-cycle implication.
`define AWNC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("awnc: property failed");

// Next-cycle implication.
`define AWNC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("awnc: property failed");

`endif

// ===== hw/rtl/awnc_pkg.sv =====
package awnc_pkg;

	localparam int COEF_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int COORD_W  = 12;
	localparam int CH_W     = 2;
	localparam int PIX_W    = 8;
	localparam int SIZE_W   = 9;
	localparam int APB_AW   = 5;
	localparam int APB_DW   = 32;

	// result queue and its credit counter
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = 3;
	localparam int QCNT_W      = 4;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd65536;
	localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;
	localparam logic [SIZE_W-1:0]        SIZE_RST  = 9'd256;

	typedef enum logic [2:0] {
		REG_COEF_XX      = 3'd0,
		REG_COEF_XY      = 3'd1,
		REG_COEF_XT      = 3'd2,
		REG_COEF_YX      = 3'd3,
		REG_COEF_YY      = 3'd4,
		REG_COEF_YT      = 3'd5,
		REG_IMAGE_WIDTH  = 3'd6,
		REG_IMAGE_HEIGHT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_xx;
		logic signed [COEF_W-1:0] coef_xy;
		logic signed [COEF_W-1:0] coef_xt;
		logic signed [COEF_W-1:0] coef_yx;
		logic signed [COEF_W-1:0] coef_yy;
		logic signed [COEF_W-1:0] coef_yt;
		logic [SIZE_W-1:0]        image_width;
		logic [SIZE_W-1:0]        image_height;
	} cfg_t;

endpackage

// ===== hw/rtl/awnc_req_if.sv =====
interface awnc_req_if;
	import awnc_pkg::*;

	logic               valid;
	logic               ready;
	logic               kind;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;
	logic [CH_W-1:0]    channel;
	logic [PIX_W-1:0]   pixel_in;

	modport source (
		output valid, kind, coord_x, coord_y, channel, pixel_in,
		input  ready
	);

	modport sink (
		input  valid, kind, coord_x, coord_y, channel, pixel_in,
		output ready
	);

endinterface

// ===== hw/rtl/awnc_rsp_if.sv =====
interface awnc_rsp_if;
	import awnc_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;

	modport source (
		output valid, pixel_out,
		input  ready
	);

	modport sink (
		input  valid, pixel_out,
		output ready
	);

endinterface

// ===== hw/rtl/awnc_regs.sv =====
module awnc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [awnc_pkg::APB_AW-1:0] paddr,
	input  logic [awnc_pkg::APB_DW-1:0] pwdata,
	output logic [awnc_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output awnc_pkg::cfg_t              cfg
);
	import awnc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_xx      <= COEF_ONE;
			cfg_q.coef_xy      <= COEF_ZERO;
			cfg_q.coef_xt      <= COEF_ZERO;
			cfg_q.coef_yx      <= COEF_ZERO;
			cfg_q.coef_yy      <= COEF_ONE;
			cfg_q.coef_yt      <= COEF_ZERO;
			cfg_q.image_width  <= SIZE_RST;
			cfg_q.image_height <= SIZE_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_COEF_XX:      cfg_q.coef_xx      <= $signed(pwdata);
				REG_COEF_XY:      cfg_q.coef_xy      <= $signed(pwdata);
				REG_COEF_XT:      cfg_q.coef_xt      <= $signed(pwdata);
				REG_COEF_YX:      cfg_q.coef_yx      <= $signed(pwdata);
				REG_COEF_YY:      cfg_q.coef_yy      <= $signed(pwdata);
				REG_COEF_YT:      cfg_q.coef_yt      <= $signed(pwdata);
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[SIZE_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_COEF_XX:      prdata = cfg_q.coef_xx;
			REG_COEF_XY:      prdata = cfg_q.coef_xy;
			REG_COEF_XT:      prdata = cfg_q.coef_xt;
			REG_COEF_YX:      prdata = cfg_q.coef_yx;
			REG_COEF_YY:      prdata = cfg_q.coef_yy;
			REG_COEF_YT:      prdata = cfg_q.coef_yt;
			REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_q.image_width);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_q.image_height);
		endcase
	end

endmodule

// ===== hw/rtl/awnc_axis.sv =====
// One source axis: a*x + b*y + t*size in Q.16, truncated toward zero and
// clamped to 0..size-1. Three register stages, no stall.
module awnc_axis #(
	parameter int SW    = 9,
	parameter int OUT_W = 8
) (
	input  logic                                clk,
	input  logic signed [awnc_pkg::COEF_W-1:0]  coef_a,
	input  logic signed [awnc_pkg::COEF_W-1:0]  coef_b,
	input  logic signed [awnc_pkg::COEF_W-1:0]  coef_t,
	input  logic        [awnc_pkg::COORD_W-1:0] x,
	input  logic        [awnc_pkg::COORD_W-1:0] y,
	input  logic        [SW-1:0]                size,
	output logic        [OUT_W-1:0]             coord_s4
);
	import awnc_pkg::*;

	localparam int MW    = ((COORD_W > SW) ? COORD_W : SW) + 1;
	localparam int PW    = COEF_W + MW;
	localparam int ACC_W = PW + 2;
	localparam int QW    = ACC_W - FRAC_W;

	logic signed [MW-1:0]    x_ext, y_ext, size_ext;
	logic signed [PW-1:0]    prod_a_s2, prod_b_s2, prod_t_s2;
	logic        [SW-1:0]    size_s2, size_s3;
	logic signed [ACC_W-1:0] acc_s3;
	logic        [QW-1:0]    quot;

	assign x_ext    = $signed(MW'(x));
	assign y_ext    = $signed(MW'(y));
	assign size_ext = $signed(MW'(size));

	// widen both factors so the full product is kept
	always_ff @(posedge clk) begin
		prod_a_s2 <= PW'(coef_a) * PW'(x_ext);
		prod_b_s2 <= PW'(coef_b) * PW'(y_ext);
		prod_t_s2 <= PW'(coef_t) * PW'(size_ext);
		size_s2   <= size;
	end

	always_ff @(posedge clk) begin
		acc_s3  <= ACC_W'(prod_a_s2) + ACC_W'(prod_b_s2) + ACC_W'(prod_t_s2);
		size_s3 <= size_s2;
	end

	// a negative sum truncates to zero or below, so it clamps to 0
	assign quot = acc_s3[ACC_W-1:FRAC_W];

	always_ff @(posedge clk) begin
		if (acc_s3[ACC_W-1]) begin
			coord_s4 <= '0;
		end else if (quot >= QW'(size_s3)) begin
			coord_s4 <= OUT_W'(size_s3 - SW'(1));
		end else begin
			coord_s4 <= OUT_W'(quot);
		end
	end

endmodule

// ===== hw/rtl/affine_warp_nearest_clamp.sv =====
// A read's result passes s1, the axis stages, rd_s5 and the result queue.
// Throughput: one transaction per cycle, load or read; the single-port image
// memory serves one access per cycle at the fourth stage.
// An 8-entry result queue with credits stalls requests only when results back up.
// Reset: clears valids, queue, credits and registers (identity, 256x256);
// the image memory is not cleared and holds garbage until loaded.
`include "affine_warp_nearest_clamp_assert.svh"

module affine_warp_nearest_clamp #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int CHANNELS   = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [awnc_pkg::APB_AW-1:0] paddr,
	input  logic [awnc_pkg::APB_DW-1:0] pwdata,
	output logic [awnc_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	awnc_req_if.sink                    pixel_req,
	awnc_rsp_if.source                  pixel_rsp
);
	import awnc_pkg::*;

	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SWX   = $clog2(MAX_WIDTH + 1);
	localparam int SWY   = $clog2(MAX_HEIGHT + 1);
	localparam int CMPX  = (SWX > SIZE_W) ? SWX : SIZE_W;
	localparam int CMPY  = (SWY > SIZE_W) ? SWY : SIZE_W;
	localparam int LCX   = (SWX > COORD_W) ? SWX : COORD_W;
	localparam int LCY   = (SWY > COORD_W) ? SWY : COORD_W;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic             kind;
		logic             ok;
		logic [XW-1:0]    lx;
		logic [YW-1:0]    ly;
		logic [CW-1:0]    ch;
		logic [PIX_W-1:0] pix;
	} carry_t;

	cfg_t cfg;

	logic [SWX-1:0] w_eff;
	logic [SWY-1:0] h_eff;

	logic               req_fire, rsp_fire;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               kind_s1;
	logic [COORD_W-1:0] cx_s1, cy_s1;
	logic [CH_W-1:0]    ch_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic               load_ok_s1, ch_ok_s1;
	carry_t             carry_s1, carry_s2, carry_s3, carry_s4;
	logic [XW-1:0]      sx_s4;
	logic [YW-1:0]      sy_s4;

	logic [XW-1:0]    mem_x;
	logic [YW-1:0]    mem_y;
	logic [AW-1:0]    mem_addr;
	logic             mem_we, mem_re;
	logic [PIX_W-1:0] image_mem [DEPTH];
	logic [PIX_W-1:0] rd_s5;
	logic             zero_s5;

	logic [PIX_W-1:0]  queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] qcnt_q, credit_q;
	logic              credit_inc;

	awnc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// effective sizes saturate to 1..MAX
	always_comb begin
		if (cfg.image_width == '0) begin
			w_eff = SWX'(1);
		end else if (CMPX'(cfg.image_width) > CMPX'(MAX_WIDTH)) begin
			w_eff = SWX'(MAX_WIDTH);
		end else begin
			w_eff = SWX'(cfg.image_width);
		end
		if (cfg.image_height == '0) begin
			h_eff = SWY'(1);
		end else if (CMPY'(cfg.image_height) > CMPY'(MAX_HEIGHT)) begin
			h_eff = SWY'(MAX_HEIGHT);
		end else begin
			h_eff = SWY'(cfg.image_height);
		end
	end

	assign pixel_req.ready = (credit_q != QCNT_W'(QUEUE_DEPTH));
	assign req_fire        = pixel_req.valid && pixel_req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= req_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && (carry_s4.kind == KIND_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_s1 <= pixel_req.kind;
			cx_s1   <= pixel_req.coord_x;
			cy_s1   <= pixel_req.coord_y;
			ch_s1   <= pixel_req.channel;
			pix_s1  <= pixel_req.pixel_in;
		end
	end

	assign ch_ok_s1   = ({1'b0, ch_s1} < (CH_W + 1)'(CHANNELS));
	assign load_ok_s1 = (LCX'(cx_s1) < LCX'(w_eff)) && (LCY'(cy_s1) < LCY'(h_eff)) && ch_ok_s1;

	always_comb begin
		carry_s1.kind = kind_s1;
		carry_s1.ok   = (kind_s1 == KIND_READ) ? ch_ok_s1 : load_ok_s1;
		carry_s1.lx   = XW'(cx_s1);
		carry_s1.ly   = YW'(cy_s1);
		carry_s1.ch   = CW'(ch_s1);
		carry_s1.pix  = pix_s1;
	end

	always_ff @(posedge clk) begin
		carry_s2 <= carry_s1;
		carry_s3 <= carry_s2;
		carry_s4 <= carry_s3;
	end

	awnc_axis #(.SW(SWX), .OUT_W(XW)) u_axis_x (
		.clk      (clk),
		.coef_a   (cfg.coef_xx),
		.coef_b   (cfg.coef_xy),
		.coef_t   (cfg.coef_xt),
		.x        (cx_s1),
		.y        (cy_s1),
		.size     (w_eff),
		.coord_s4 (sx_s4)
	);

	awnc_axis #(.SW(SWY), .OUT_W(YW)) u_axis_y (
		.clk      (clk),
		.coef_a   (cfg.coef_yx),
		.coef_b   (cfg.coef_yy),
		.coef_t   (cfg.coef_yt),
		.x        (cx_s1),
		.y        (cy_s1),
		.size     (h_eff),
		.coord_s4 (sy_s4)
	);

	// Loads and reads reach the memory in arrival order at one stage, so a
	// read always sees every earlier load without forwarding.
	assign mem_x    = (carry_s4.kind == KIND_READ) ? sx_s4 : carry_s4.lx;
	assign mem_y    = (carry_s4.kind == KIND_READ) ? sy_s4 : carry_s4.ly;
	assign mem_addr = AW'((AW'(mem_y) * AW'(MAX_WIDTH) + AW'(mem_x)) * AW'(CHANNELS)
		+ AW'(carry_s4.ch));
	assign mem_we   = v_s4 && (carry_s4.kind == KIND_LOAD) && carry_s4.ok;
	assign mem_re   = v_s4 && (carry_s4.kind == KIND_READ) && carry_s4.ok;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			image_mem[mem_addr] <= carry_s4.pix;
		end
		if (mem_re) begin
			rd_s5 <= image_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		zero_s5 <= !carry_s4.ok;
	end

	// result queue
	assign rsp_fire            = pixel_rsp.valid && pixel_rsp.ready;
	assign pixel_rsp.valid     = (qcnt_q != '0);
	assign pixel_rsp.pixel_out = queue_q[rptr_q];
	assign credit_inc          = req_fire && (pixel_req.kind == KIND_READ);

	always_ff @(posedge clk) begin
		if (v_s5) begin
			queue_q[wptr_q] <= zero_s5 ? '0 : rd_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			rptr_q   <= '0;
			qcnt_q   <= '0;
			credit_q <= '0;
		end else begin
			if (v_s5) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (rsp_fire) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			priority if (v_s5 && !rsp_fire) begin
				qcnt_q <= qcnt_q + QCNT_W'(1);
			end else if (!v_s5 && rsp_fire) begin
				qcnt_q <= qcnt_q - QCNT_W'(1);
			end
			priority if (credit_inc && !rsp_fire) begin
				credit_q <= credit_q + QCNT_W'(1);
			end else if (!credit_inc && rsp_fire) begin
				credit_q <= credit_q - QCNT_W'(1);
			end
		end
	end

	`AWNC_ASSERT_IMPL(a_credit_max, 1'b1, credit_q <= QCNT_W'(QUEUE_DEPTH))
	`AWNC_ASSERT_IMPL(a_queue_le_credit, 1'b1, qcnt_q <= credit_q)
	`AWNC_ASSERT_IMPL(a_no_overflow, v_s5, qcnt_q != QCNT_W'(QUEUE_DEPTH))
	`AWNC_ASSERT_IMPL(a_one_access, 1'b1, !(mem_we && mem_re))
	`AWNC_ASSERT_NEXT(a_credit_up, credit_inc && !rsp_fire, credit_q == $past(credit_q) + QCNT_W'(1))

endmodule

// ===== test/affine_warp_nearest_clamp_tb.sv =====
`timescale 1ns / 100ps

module affine_warp_nearest_clamp_tb;
	import awnc_pkg::*;

	localparam int MAX_W       = 256;
	localparam int MAX_H       = 256;
	localparam int CHANNELS    = 4;
	localparam int STORE_DEPTH = MAX_W * MAX_H * CHANNELS;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] coord_x;
		logic [COORD_W-1:0] coord_y;
		logic [CH_W-1:0]    channel;
		logic [PIX_W-1:0]   pixel_in;
	} pixel_req_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	logic       drv_valid = 1'b0;
	pixel_req_t drv_item  = '0;
	logic       rsp_ready = 1'b0;

	awnc_req_if pixel_req_if ();
	awnc_rsp_if pixel_rsp_if ();

	assign pixel_req_if.valid    = drv_valid;
	assign pixel_req_if.kind     = drv_item.kind;
	assign pixel_req_if.coord_x  = drv_item.coord_x;
	assign pixel_req_if.coord_y  = drv_item.coord_y;
	assign pixel_req_if.channel  = drv_item.channel;
	assign pixel_req_if.pixel_in = drv_item.pixel_in;
	assign pixel_rsp_if.ready    = rsp_ready;

	affine_warp_nearest_clamp #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H),
		.CHANNELS   (CHANNELS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pixel_req (pixel_req_if),
		.pixel_rsp (pixel_rsp_if)
	);

	// Predicted block state
	cfg_t       warp_cfg = '{
		coef_xx: COEF_ONE, coef_xy: COEF_ZERO, coef_xt: COEF_ZERO,
		coef_yx: COEF_ZERO, coef_yy: COEF_ONE, coef_yt: COEF_ZERO,
		image_width: SIZE_RST, image_height: SIZE_RST
	};
	logic [PIX_W-1:0] src_image [0:STORE_DEPTH-1];

	// Stimulus bookkeeping: which pixels the generated loads have defined
	bit         src_loaded [0:STORE_DEPTH-1];
	int         gen_w = MAX_W;
	int         gen_h = MAX_H;

	pixel_req_t       pending_req_q [$];
	logic [PIX_W-1:0] warped_pixel_q [$];
	int               fail_count = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int eff_size(logic [SIZE_W-1:0] v, int maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic int pix_addr(int x, int y, int c);
		return (y * MAX_W + x) * CHANNELS + c;
	endfunction

	// Exact Q.16 sum, truncated toward zero, clamped to the image edge
	function automatic int warp_axis(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
		logic signed [COEF_W-1:0] t, int x, int y, int size);
		longint acc;
		longint q;
		acc = longint'(a) * x + longint'(b) * y + longint'(t) * size;
		q = acc / 65536;
		if (q < 0) return 0;
		if (q > size - 1) return size - 1;
		return int'(q);
	endfunction

	function automatic void warp_predict(pixel_req_t it);
		int w;
		int h;
		int x;
		int y;
		int c;
		int sx;
		int sy;
		w = eff_size(warp_cfg.image_width, MAX_W);
		h = eff_size(warp_cfg.image_height, MAX_H);
		x = int'(it.coord_x);
		y = int'(it.coord_y);
		c = int'(it.channel);
		if (it.kind == KIND_LOAD) begin
			if (x < w && y < h && c < CHANNELS)
				src_image[pix_addr(x, y, c)] = it.pixel_in;
		end else if (c >= CHANNELS) begin
			warped_pixel_q.push_back('0);
		end else begin
			sx = warp_axis(warp_cfg.coef_xx, warp_cfg.coef_xy, warp_cfg.coef_xt, x, y, w);
			sy = warp_axis(warp_cfg.coef_yx, warp_cfg.coef_yy, warp_cfg.coef_yt, x, y, h);
			warped_pixel_q.push_back(src_image[pix_addr(sx, sy, c)]);
		end
	endfunction

	function automatic void queue_item(logic kind, int x, int y, int c, int p);
		pixel_req_t it;
		it.kind     = kind;
		it.coord_x  = COORD_W'(x);
		it.coord_y  = COORD_W'(y);
		it.channel  = CH_W'(c);
		it.pixel_in = PIX_W'(p);
		if (kind == KIND_LOAD && x < gen_w && y < gen_h && c < CHANNELS)
			src_loaded[pix_addr(x, y, c)] = 1'b1;
		pending_req_q.push_back(it);
	endfunction

	// Reads near the image or anywhere, overwriting loads, and loads off the image
	function automatic void queue_mixed();
		int r;
		int x;
		int y;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			x = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, gen_w + 3);
			y = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, gen_h + 3);
			queue_item(KIND_READ, x, y, $urandom_range(0, 3), $urandom_range(0, 255));
		end else if (r < 9) begin
			queue_item(KIND_LOAD, $urandom_range(0, gen_w - 1), $urandom_range(0, gen_h - 1),
				$urandom_range(0, 3), $urandom_range(0, 255));
		end else if ($urandom_range(0, 1) == 1) begin
			queue_item(KIND_LOAD, $urandom_range(gen_w, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 3), $urandom_range(0, 255));
		end else begin
			queue_item(KIND_LOAD, $urandom_range(0, 4095), $urandom_range(gen_h, 4095),
				$urandom_range(0, 3), $urandom_range(0, 255));
		end
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef(bit diag);
		case ($urandom_range(0, 6))
			0: return $urandom();
			1: return COEF_W'($urandom_range(0, 32'h0003_0000) - 32'h0001_8000);
			2: return diag ? COEF_ONE : COEF_ZERO;
			3: return COEF_ZERO;
			4: return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
			5: return COEF_ONE;
			default: return -COEF_ONE;
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		if ($urandom_range(0, 9) == 0) return '0;
		return SIZE_W'($urandom_range(1, 12));
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_COEF_XX:      warp_cfg.coef_xx = value;
			REG_COEF_XY:      warp_cfg.coef_xy = value;
			REG_COEF_XT:      warp_cfg.coef_xt = value;
			REG_COEF_YX:      warp_cfg.coef_yx = value;
			REG_COEF_YY:      warp_cfg.coef_yy = value;
			REG_COEF_YT:      warp_cfg.coef_yt = value;
			REG_IMAGE_WIDTH:  warp_cfg.image_width = value[SIZE_W-1:0];
			REG_IMAGE_HEIGHT: warp_cfg.image_height = value[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	// Loads cause no result, so let the pipeline drain after the queues empty
	task automatic wait_idle();
		@(negedge clk);
		while (pending_req_q.size() != 0 || drv_valid || warped_pixel_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(cfg_t c, int n_mixed);
		int x;
		int y;
		int ch;
		wait_idle();
		write_reg(REG_COEF_XX, c.coef_xx);
		write_reg(REG_COEF_XY, c.coef_xy);
		write_reg(REG_COEF_XT, c.coef_xt);
		write_reg(REG_COEF_YX, c.coef_yx);
		write_reg(REG_COEF_YY, c.coef_yy);
		write_reg(REG_COEF_YT, c.coef_yt);
		write_reg(REG_IMAGE_WIDTH, APB_DW'(c.image_width));
		write_reg(REG_IMAGE_HEIGHT, APB_DW'(c.image_height));
		gen_w = eff_size(c.image_width, MAX_W);
		gen_h = eff_size(c.image_height, MAX_H);
		// define every pixel a read could land on
		for (y = 0; y < gen_h; y++)
			for (x = 0; x < gen_w; x++)
				for (ch = 0; ch < CHANNELS; ch++)
					if (!src_loaded[pix_addr(x, y, ch)])
						queue_item(KIND_LOAD, x, y, ch, $urandom_range(0, 255));
		repeat (n_mixed) queue_mixed();
	endtask

	// Driver: bursts of random length separated by random gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && pixel_req_if.ready)
				warp_predict(drv_item);
			if (!drv_valid || pixel_req_if.ready) begin
				if (gap_left > 0) begin
					gap_left = gap_left - 1;
					drv_valid <= 1'b0;
				end else if (pending_req_q.size() > 0) begin
					drv_item  <= pending_req_q.pop_front();
					drv_valid <= 1'b1;
					burst_left = burst_left - 1;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks results and stalls the result channel on its own pattern
	int ready_mode    = 0;
	int mode_left     = 0;
	int hold_left     = 0;
	int long_holds    = 0;
	int pixels_seen   = 0;
	int next_hold_at  = 150;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (pixel_rsp_if.valid && pixel_rsp_if.ready) begin
				pixels_seen = pixels_seen + 1;
				if (warped_pixel_q.size() == 0) begin
					$error("pixel_out: expected none, actual %0d", pixel_rsp_if.pixel_out);
					fail_count = fail_count + 1;
				end else if (warped_pixel_q[0] !== pixel_rsp_if.pixel_out) begin
					$error("pixel_out: expected %0d, actual %0d",
						warped_pixel_q[0], pixel_rsp_if.pixel_out);
					fail_count = fail_count + 1;
					void'(warped_pixel_q.pop_front());
				end else begin
					void'(warped_pixel_q.pop_front());
				end
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (long_holds < 3 && pixels_seen >= next_hold_at
				&& pending_req_q.size() > 40) begin
				// hold off long enough to fill the result queue and stall requests
				hold_left = 300;
				long_holds = long_holds + 1;
				next_hold_at = next_hold_at + 400;
				rsp_ready <= 1'b0;
			end else begin
				if (mode_left <= 0) begin
					ready_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 200);
				end else begin
					mode_left = mode_left - 1;
				end
				case (ready_mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= ($urandom_range(0, 1) == 1);
					default: rsp_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		cfg_t c;
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: identity on a full-size image, corners only
		queue_item(KIND_LOAD, 0, 0, 0, 8'h00);
		queue_item(KIND_LOAD, 255, 0, 0, 8'hff);
		queue_item(KIND_LOAD, 0, 255, 0, 8'h5a);
		queue_item(KIND_LOAD, 255, 255, 0, 8'ha5);
		queue_item(KIND_LOAD, 0, 0, 3, 8'hff);
		queue_item(KIND_LOAD, 255, 0, 3, 8'h01);
		queue_item(KIND_LOAD, 0, 255, 3, 8'h80);
		queue_item(KIND_LOAD, 255, 255, 3, 8'h7f);
		// loads off the image are dropped
		queue_item(KIND_LOAD, 256, 5, 0, 8'h33);
		queue_item(KIND_LOAD, 7, 4095, 3, 8'h44);
		queue_item(KIND_LOAD, 4095, 4095, 0, 8'h55);
		queue_item(KIND_READ, 0, 0, 0, 8'h00);
		queue_item(KIND_READ, 4095, 4095, 3, 8'hff);
		queue_item(KIND_READ, 4095, 0, 0, 8'h00);
		queue_item(KIND_READ, 0, 4095, 3, 8'hff);
		queue_item(KIND_READ, 255, 255, 0, 8'h00);
		queue_item(KIND_READ, 0, 0, 3, 8'h00);
		queue_item(KIND_READ, 300, 0, 0, 8'h00);
		queue_item(KIND_READ, 255, 300, 3, 8'h00);

		// Oversized width saturates to the maximum, zero height to one
		c = warp_cfg;
		c.image_width  = 9'd511;
		c.image_height = 9'd0;
		run_phase(c, 60);

		c.coef_xx = COEF_ZERO;
		c.coef_xy = 32'h0000_8000;
		c.coef_xt = -COEF_ONE;
		c.coef_yx = 32'h0000_4000;
		c.coef_yy = 32'h0002_0000;
		c.coef_yt = 32'h0000_8000;
		c.image_width  = 9'd0;
		c.image_height = 9'd511;
		run_phase(c, 60);

		c.coef_xx = 32'h8000_0000;
		c.coef_xy = 32'h7fff_ffff;
		c.coef_xt = 32'h8000_0000;
		c.coef_yx = 32'h7fff_ffff;
		c.coef_yy = 32'h8000_0000;
		c.coef_yt = 32'h7fff_ffff;
		c.image_width  = 9'd256;
		c.image_height = 9'd1;
		run_phase(c, 60);

		c.coef_xx = 32'h7fff_ffff;
		c.coef_xy = 32'h8000_0000;
		c.coef_xt = 32'h7fff_ffff;
		c.coef_yx = 32'h8000_0000;
		c.coef_yy = 32'h7fff_ffff;
		c.coef_yt = 32'h8000_0000;
		run_phase(c, 60);

		for (k = 0; k < 8; k++) begin
			c.coef_xx = pick_coef(1'b1);
			c.coef_xy = pick_coef(1'b0);
			c.coef_xt = pick_coef(1'b0);
			c.coef_yx = pick_coef(1'b0);
			c.coef_yy = pick_coef(1'b1);
			c.coef_yt = pick_coef(1'b0);
			c.image_width  = pick_size();
			c.image_height = pick_size();
			run_phase(c, 180);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
